@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Assert a property sampled on clk_i, disabled while rst_ni is low
`define TKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert that a condition holds whenever the enable is high
`define TKC_ASSERT_IF(lbl, en, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (en) |-> (cond)) \
    else $error(msg);

`else

`define TKC_ASSERT(lbl, prop, msg)
`define TKC_ASSERT_IF(lbl, en, cond, msg)

`endif

`endif

@@ src/tkc_pkg.sv @@
// ----------------------------------------------------------------------------
// tkc_pkg
// Types and fixed constants of the two-key chord recognizer.
// ----------------------------------------------------------------------------
package tkc_pkg;

  // Field widths fixed by the stream format
  localparam int CmdW      = 2;
  localparam int KeyW      = 16;
  localparam int ModW      = 4;
  localparam int ActionW   = 8;
  localparam int TimeoutW  = 16;
  localparam int ElapsedW  = 17;
  localparam int STdataW   = 24;  // key_code + modifier_bits, padded to bytes
  localparam int MTdataW   = 8;   // action_id
  localparam int CfgIdxW   = 3;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTimeout   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEntryBase = 3'd1;

  // Item kinds carried in s_axis_tuser
  typedef enum logic [CmdW-1:0] {
    CMD_KEY    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_e;

  // Result kinds carried in m_axis_tuser
  typedef enum logic [CmdW-1:0] {
    OUT_PASS     = 2'd0,
    OUT_PENDING  = 2'd1,
    OUT_COMPLETE = 2'd2
  } outcome_e;

  // Status from the chord matcher
  typedef struct packed {
    logic any_lead;    // key matches the lead chord of some valid entry
    logic second_hit;  // key matches the second chord of a valid candidate
  } match_status_t;

endpackage

@@ src/tkc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tkc_cfg_regs
// Configuration register file: timeout and the packed sequence entries.
// ----------------------------------------------------------------------------
module tkc_cfg_regs #(
  parameter int NUM_SEQUENCES = 6,
  parameter int KEY_BITS      = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tkc_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [2*KEY_BITS+16:0]                 cfg_data_i,
  output logic [tkc_pkg::TimeoutW-1:0]           timeout_o,
  output logic [NUM_SEQUENCES-1:0][2*KEY_BITS+16:0] entries_o
);

  localparam int EntryW = 2 * KEY_BITS + 17;
  localparam int IdxW   = tkc_pkg::CfgIdxW;

  logic [tkc_pkg::TimeoutW-1:0]       timeout_q;
  logic [NUM_SEQUENCES-1:0][EntryW-1:0] entry_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tkc_pkg::TimeoutReset;
    end else if (cfg_valid_i && cfg_index_i == tkc_pkg::RegTimeout) begin
      timeout_q <= cfg_data_i[tkc_pkg::TimeoutW-1:0];
    end
  end

  // Sequence entries; reset clears the valid bits with the rest
  for (genvar i = 0; i < NUM_SEQUENCES; i++) begin : g_entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entry_q[i] <= '0;
      end else if (cfg_valid_i &&
                   cfg_index_i == IdxW'(i) + tkc_pkg::RegEntryBase) begin
        entry_q[i] <= cfg_data_i;
      end
    end
  end

  assign timeout_o = timeout_q;
  assign entries_o = entry_q;

endmodule

@@ src/tkc_match.sv @@
// ----------------------------------------------------------------------------
// tkc_match
// Parallel chord compare against all entries and lowest-entry pick.
// ----------------------------------------------------------------------------
module tkc_match #(
  parameter int NUM_SEQUENCES = 6,
  parameter int KEY_BITS      = 16
) (
  input  logic [NUM_SEQUENCES-1:0][2*KEY_BITS+16:0] entries_i,
  input  logic [NUM_SEQUENCES-1:0]                  cand_i,
  input  logic [tkc_pkg::KeyW-1:0]                  key_i,
  input  logic [tkc_pkg::ModW-1:0]                  mod_i,
  output logic [NUM_SEQUENCES-1:0]                  lead_mask_o,
  output logic [tkc_pkg::ActionW-1:0]               action_o,
  output tkc_pkg::match_status_t                    status_o
);

  localparam int ModW      = tkc_pkg::ModW;
  localparam int LeadModLo = KEY_BITS;
  localparam int SecKeyLo  = KEY_BITS + ModW;
  localparam int SecModLo  = 2 * KEY_BITS + ModW;
  localparam int ActionLo  = 2 * KEY_BITS + 2 * ModW;
  localparam int ValidBit  = 2 * KEY_BITS + 16;
  localparam int WideW     = (KEY_BITS > tkc_pkg::KeyW) ? KEY_BITS : tkc_pkg::KeyW;

  logic [WideW-1:0]          key_wide;
  logic [KEY_BITS-1:0]       key_cmp;
  logic [NUM_SEQUENCES-1:0]  sec_hit;

  // Compare only the low KEY_BITS of the key, zero-extended when wider
  assign key_wide = WideW'(key_i);
  assign key_cmp  = key_wide[KEY_BITS-1:0];

  // Per-entry lead and second chord compare
  for (genvar i = 0; i < NUM_SEQUENCES; i++) begin : g_cmp
    logic valid;
    assign valid = entries_i[i][ValidBit];
    assign lead_mask_o[i] = valid &&
        entries_i[i][KEY_BITS-1:0] == key_cmp &&
        entries_i[i][LeadModLo +: ModW] == mod_i;
    assign sec_hit[i] = valid && cand_i[i] &&
        entries_i[i][SecKeyLo +: KEY_BITS] == key_cmp &&
        entries_i[i][SecModLo +: ModW] == mod_i;
  end

  // Pick the action of the lowest hitting entry
  always_comb begin
    action_o = '0;
    for (int i = NUM_SEQUENCES - 1; i >= 0; i--) begin
      if (sec_hit[i]) begin
        action_o = entries_i[i][ActionLo +: tkc_pkg::ActionW];
      end
    end
  end

  assign status_o.any_lead   = |lead_mask_o;
  assign status_o.second_hit = |sec_hit;

endmodule

@@ src/two_key_chord_recognizer.sv @@
// ----------------------------------------------------------------------------
// two_key_chord_recognizer
// Two-key shortcut recognizer with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel: tuser carries the kind (key event,
//   tick, cancel), tdata the key code and modifiers. Each key event yields
//   one result on m_axis: tuser the outcome (passthrough, pending, completed)
//   and tdata the completed action. Ticks and cancels yield nothing. The cfg
//   channel is always ready and writes the timeout (index 0) and the sequence
//   entries (index 1 up); users write only while the block is idle (unenforced).
// Timing:
//   An accepted item is matched and updates the state while it sits in the input
//   register; a key event waits there while a held result is not taken. Its
//   result is loaded into the output register when it is processed. One item
//   per cycle is taken while no key event is held; the limit is the combinational
//   compare of all entries followed by the lowest-entry pick.
// Reset clears the pending lead, the candidate mask, the tick counter, all
// entries and sets the timeout to 1000. When the receiver stalls, the result
// holds; ticks and cancels keep flowing until a key event reaches the input
// register, which then waits there and holds off further transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_key_chord_recognizer #(
  parameter int NUM_SEQUENCES = 6,
  parameter int KEY_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Item stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tkc_pkg::STdataW-1:0]    s_axis_tdata,  // key_code[15:0], modifier_bits[19:16]
  input  logic [tkc_pkg::CmdW-1:0]       s_axis_tuser,  // cmd[1:0]
  // Result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tkc_pkg::MTdataW-1:0]    m_axis_tdata,  // action_id[7:0]
  output logic [tkc_pkg::CmdW-1:0]       m_axis_tuser,  // outcome[1:0]
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tkc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [2*KEY_BITS+16:0]         cfg_data_i
);

  localparam int KeyW     = tkc_pkg::KeyW;
  localparam int ModW     = tkc_pkg::ModW;
  localparam int ElapsedW = tkc_pkg::ElapsedW;

  // Configuration
  logic [tkc_pkg::TimeoutW-1:0]                timeout;
  logic [NUM_SEQUENCES-1:0][2*KEY_BITS+16:0]   entries;

  // Input stage
  logic                     in_vld_q, in_vld_d;
  logic [tkc_pkg::CmdW-1:0] in_cmd_q;
  logic [KeyW-1:0]          in_key_q;
  logic [ModW-1:0]          in_mod_q;

  // Recognizer state
  logic                     armed_q, armed_d;
  logic [NUM_SEQUENCES-1:0] cand_q, cand_d;
  logic [ElapsedW-1:0]      elapsed_q, elapsed_d;

  // Result stage
  logic                          out_vld_q, out_vld_d;
  tkc_pkg::outcome_e             out_outcome_q, res_outcome;
  logic [tkc_pkg::ActionW-1:0]   out_action_q, res_action;

  // Matcher outputs
  logic [NUM_SEQUENCES-1:0]      lead_mask;
  logic [tkc_pkg::ActionW-1:0]   hit_action;
  tkc_pkg::match_status_t        status;

  logic is_key, advance, in_time, complete;

  tkc_cfg_regs #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .KEY_BITS      (KEY_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timeout_o   (timeout),
    .entries_o   (entries)
  );

  tkc_match #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .KEY_BITS      (KEY_BITS)
  ) u_match (
    .entries_i   (entries),
    .cand_i      (cand_q),
    .key_i       (in_key_q),
    .mod_i       (in_mod_q),
    .lead_mask_o (lead_mask),
    .action_o    (hit_action),
    .status_o    (status)
  );

  // Advance the input item unless it is a key event blocked by a held result
  assign is_key        = in_cmd_q == tkc_pkg::CMD_KEY;
  assign advance       = in_vld_q && (!is_key || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_vld_d      = s_axis_tvalid ? 1'b1 : (in_vld_q && !advance);

  assign in_time  = elapsed_q <= ElapsedW'(timeout);
  assign complete = armed_q && in_time && status.second_hit;

  // Item processing: state update and result selection
  always_comb begin
    armed_d     = armed_q;
    cand_d      = cand_q;
    elapsed_d   = elapsed_q;
    res_outcome = tkc_pkg::OUT_PASS;
    res_action  = '0;
    if (advance) begin
      unique case (in_cmd_q)
        tkc_pkg::CMD_TICK: begin
          if (elapsed_q != '1) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        tkc_pkg::CMD_CANCEL: begin
          armed_d = 1'b0;
          cand_d  = '0;
        end
        tkc_pkg::CMD_KEY: begin
          armed_d = 1'b0;
          cand_d  = '0;
          if (complete) begin
            res_outcome = tkc_pkg::OUT_COMPLETE;
            res_action  = hit_action;
          end else if (status.any_lead) begin
            armed_d     = 1'b1;
            cand_d      = lead_mask;
            elapsed_d   = '0;
            res_outcome = tkc_pkg::OUT_PENDING;
          end
        end
        default: begin
          // unused kind: drop
        end
      endcase
    end
  end

  // Result valid: set by a processed key event, clear on transfer
  assign out_vld_d = (advance && is_key) ? 1'b1 : (out_vld_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      armed_q   <= 1'b0;
      cand_q    <= '0;
      elapsed_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      armed_q   <= armed_d;
      cand_q    <= cand_d;
      elapsed_q <= elapsed_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input payload: load on transfer
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= s_axis_tuser;
      in_key_q <= s_axis_tdata[KeyW-1:0];
      in_mod_q <= s_axis_tdata[KeyW +: ModW];
    end
  end

  // Result payload: load when a key event is processed
  always_ff @(posedge clk_i) begin
    if (advance && is_key) begin
      out_outcome_q <= res_outcome;
      out_action_q  <= res_action;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_outcome_q;
  assign m_axis_tdata  = out_action_q;

  // Checks
  `TKC_ASSERT_IF(a_armed_has_cand, armed_q, cand_q != '0,
                 "armed lead without candidates")
  `TKC_ASSERT_IF(a_action_only_on_complete,
                 out_vld_q && out_outcome_q != tkc_pkg::OUT_COMPLETE,
                 out_action_q == '0, "action given without completion")
  `TKC_ASSERT(a_tick_counts,
              advance && in_cmd_q == tkc_pkg::CMD_TICK && elapsed_q != '1
              |=> elapsed_q == $past(elapsed_q) + 1'b1,
              "tick did not advance elapsed count")
  `TKC_ASSERT(a_complete_disarms, advance && is_key && complete |=> !armed_q,
              "completion left lead armed")

endmodule
